[hw/rtl/ara_pkg.sv]
// Package for the AT response recogniser: beat codes, status codes, reply patterns.
// The patterns are held in window order, so entry 0 is the newest byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ara_pkg;

  // Depth of the byte window: the longest reply pattern.
  localparam int unsigned WIN_LEN = 9;

  localparam int unsigned SENT_LEN  = 9;
  localparam int unsigned OK_LEN    = 4;
  localparam int unsigned FAIL_LEN  = 6;
  localparam int unsigned ERROR_LEN = 7;

  localparam logic [23:0] LIMIT_RESET = 24'hFF_FFFF;
  localparam logic [23:0] TICK_MAX    = 24'hFF_FFFF;

  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_PROMPT = 8'h3E;

  // Reply patterns, newest byte at index 0.
  localparam logic [SENT_LEN-1:0][7:0]  SENT_WIN  = {"SEND OK", CHR_CR, CHR_LF};
  localparam logic [OK_LEN-1:0][7:0]    OK_WIN    = {"OK", CHR_CR, CHR_LF};
  localparam logic [FAIL_LEN-1:0][7:0]  FAIL_WIN  = {"FAIL", CHR_CR, CHR_LF};
  localparam logic [ERROR_LEN-1:0][7:0] ERROR_WIN = {"ERROR", CHR_CR, CHR_LF};

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_TIMEOUT = 3'd0,
    ST_SENT    = 3'd1,
    ST_OK      = 3'd2,
    ST_FAIL    = 3'd3,
    ST_ERROR   = 3'd4,
    ST_PROMPT  = 3'd5
  } status_e;

  // Per-cell pattern hits; a position beyond a pattern's length always hits.
  typedef struct packed {
    logic sent;
    logic ok;
    logic fail;
    logic error;
  } hit_t;

  // Control from the top level to every cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/ara_cell.sv]
// One window cell of the AT response recogniser: holds one byte and compares
// the byte it is about to load against the reply patterns at its position.
// Depends on ara_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ara_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire ara_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic [7:0]           data_i,
  output logic [7:0]                data_o,
  output ara_pkg::hit_t             hit_o
);

  logic [7:0] byte_q, byte_d;

  // Advance from the neighbour on a byte beat, drop to zero on a start beat.
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = 8'h00;
    end else if (ctrl_i.shift) begin
      byte_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign data_o = byte_q;

  // Compare the incoming byte, i.e. this cell's content after the shift.
  if (Idx < ara_pkg::SENT_LEN) begin : g_sent
    assign hit_o.sent = (data_i == ara_pkg::SENT_WIN[4'(Idx)]);
  end else begin : g_sent_na
    assign hit_o.sent = 1'b1;
  end

  if (Idx < ara_pkg::OK_LEN) begin : g_ok
    assign hit_o.ok = (data_i == ara_pkg::OK_WIN[2'(Idx)]);
  end else begin : g_ok_na
    assign hit_o.ok = 1'b1;
  end

  if (Idx < ara_pkg::FAIL_LEN) begin : g_fail
    assign hit_o.fail = (data_i == ara_pkg::FAIL_WIN[3'(Idx)]);
  end else begin : g_fail_na
    assign hit_o.fail = 1'b1;
  end

  if (Idx < ara_pkg::ERROR_LEN) begin : g_error
    assign hit_o.error = (data_i == ara_pkg::ERROR_WIN[3'(Idx)]);
  end else begin : g_error_na
    assign hit_o.error = 1'b1;
  end

endmodule

`default_nettype wire

[hw/rtl/at_response_recognizer.sv]
// Channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o  | action_i, rx_byte_i, wait_prompt_i
// out     | output    | out_valid_o / out_stall_i| done_res_o, status_o, busy_res_o
// cfg     | input     | cfg_we_i (no wait)       | cfg_wdata_i (timeout limit)
//
// Every input beat gives exactly one output beat, held in the result register.
// A new beat is taken in every cycle unless in_stall_o is high; the result register is the only stage.
// Reset clears the window, the wait state, the tick count and sets the
// timeout limit to its maximum.
// in_stall_o rises only while a result is held and the output side stalls.
//
// AT response recogniser: top level. Window of nine ara_cell instances.
// Depends on ara_pkg and ara_cell.
`timescale 1ns / 1ps
`default_nettype none

module at_response_recognizer (
  input  wire               clk_i,
  input  wire               rst_ni,
  // input beats
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire logic [1:0]   action_i,
  input  wire logic [7:0]   rx_byte_i,
  input  wire logic         wait_prompt_i,
  // output beats
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic              done_res_o,
  output logic [2:0]        status_o,
  output logic              busy_res_o,
  // configuration
  input  wire               cfg_we_i,
  input  wire logic [23:0]  cfg_wdata_i
);

  localparam int unsigned WinLen = ara_pkg::WIN_LEN;

  // Handshake
  logic accept;
  logic out_valid_q, out_valid_d;

  // Wait state
  logic        waiting_q, waiting_d;
  logic        prompt_q, prompt_d;
  logic [23:0] tick_q, tick_d;
  logic [23:0] limit_q;
  logic [23:0] tick_inc;

  // Result
  logic       done_q, done_d;
  logic [2:0] status_q, status_d;
  logic       busy_q;

  // Window chain
  ara_pkg::cell_ctrl_t       cell_ctrl;
  logic [WinLen:0][7:0]      chain;
  ara_pkg::hit_t [WinLen-1:0] hits;
  ara_pkg::hit_t             hit_all;

  logic is_start, is_byte;

  // Take a beat unless a result is held and the far side stalls.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign is_start = (action_i == ara_pkg::ACT_START);
  assign is_byte  = (action_i == ara_pkg::ACT_BYTE);

  // A zero byte never enters the window; idle bytes are ignored.
  assign cell_ctrl.clear = accept & is_start;
  assign cell_ctrl.shift = accept & is_byte & waiting_q & (rx_byte_i != 8'h00);

  // Newest byte enters cell 0; each cell hands its byte to the next.
  assign chain[0] = rx_byte_i;

  for (genvar g = 0; g < WinLen; g++) begin : g_cell
    ara_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .data_i (chain[g]),
      .data_o (chain[g+1]),
      .hit_o  (hits[g])
    );
  end

  // A pattern matches when every cell agrees.
  always_comb begin
    hit_all = '{sent: 1'b1, ok: 1'b1, fail: 1'b1, error: 1'b1};
    for (int i = 0; i < WinLen; i++) begin
      hit_all.sent  = hit_all.sent  & hits[i].sent;
      hit_all.ok    = hit_all.ok    & hits[i].ok;
      hit_all.fail  = hit_all.fail  & hits[i].fail;
      hit_all.error = hit_all.error & hits[i].error;
    end
  end

  // Saturating poll counter.
  assign tick_inc = (tick_q != ara_pkg::TICK_MAX) ? tick_q + 24'd1 : tick_q;

  // Next wait state and result of the current beat.
  always_comb begin
    waiting_d = waiting_q;
    prompt_d  = prompt_q;
    tick_d    = tick_q;
    done_d    = 1'b0;
    status_d  = ara_pkg::ST_TIMEOUT;
    case (action_i)
      ara_pkg::ACT_START: begin
        waiting_d = 1'b1;
        prompt_d  = wait_prompt_i;
        tick_d    = '0;
      end
      ara_pkg::ACT_BYTE: begin
        if (cell_ctrl.shift) begin
          if (prompt_q) begin
            if (rx_byte_i == ara_pkg::CHR_PROMPT) begin
              done_d   = 1'b1;
              status_d = ara_pkg::ST_PROMPT;
            end
          end else if (hit_all.sent) begin
            done_d   = 1'b1;
            status_d = ara_pkg::ST_SENT;
          end else if (hit_all.ok) begin
            done_d   = 1'b1;
            status_d = ara_pkg::ST_OK;
          end else if (hit_all.fail) begin
            done_d   = 1'b1;
            status_d = ara_pkg::ST_FAIL;
          end else if (hit_all.error) begin
            done_d   = 1'b1;
            status_d = ara_pkg::ST_ERROR;
          end else if (rx_byte_i == ara_pkg::CHR_PROMPT) begin
            done_d   = 1'b1;
            status_d = ara_pkg::ST_PROMPT;
          end
          if (done_d) begin
            waiting_d = 1'b0;
          end
        end
      end
      ara_pkg::ACT_TICK: begin
        if (waiting_q) begin
          tick_d = tick_inc;
          // Limit lowered below the count ends the wait on the next tick.
          if (tick_inc >= limit_q) begin
            done_d    = 1'b1;
            waiting_d = 1'b0;
          end
        end
      end
      default: begin
        // Unused action code: hold everything.
      end
    endcase
  end

  // Hold the result until taken; load a new one on every accepted beat.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      waiting_q   <= 1'b0;
      prompt_q    <= 1'b0;
      tick_q      <= '0;
      limit_q     <= ara_pkg::LIMIT_RESET;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        waiting_q <= waiting_d;
        prompt_q  <= prompt_d;
        tick_q    <= tick_d;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      done_q   <= done_d;
      status_q <= status_d;
      busy_q   <= waiting_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign done_res_o  = done_q;
  assign status_o    = status_q;
  assign busy_res_o  = busy_q;

  // A result that did not end the wait carries the zero status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == ara_pkg::ST_TIMEOUT)
    else $error("status set on a beat that did not end the wait");

  // A beat that ended the wait leaves the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("busy reported after the wait ended");

  // The wait only ends on an accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(waiting_q) |-> $past(accept))
    else $error("wait ended without an accepted beat");

  // A start beat opens a fresh wait with a cleared count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.clear |=> waiting_q && (tick_q == 24'd0) && (chain[1] == 8'h00))
    else $error("start beat did not restart the wait");

endmodule

`default_nettype wire
